>>> hw/rtl/rotating_deque_core_assert.svh
// Assertion macros used by the deque core RTL file.
`ifndef ROTATING_DEQUE_CORE_ASSERT_SVH
`define ROTATING_DEQUE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RDQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/rdq_pkg.sv
// Package with the shared types, constants and helper functions of the deque.
package rdq_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int WORD_W      = 32;
    localparam int OPC_W       = 3;
    localparam int STAT_W      = 2;
    localparam int OCC_W       = 7;

    typedef logic [VALUE_WIDTH-1:0] entry_t;
    typedef logic [WORD_W-1:0]      word_t;
    typedef logic [CNT_W-1:0]       count_t;

    typedef enum logic [OPC_W-1:0] {
        OP_INS_BACK  = 3'd0,
        OP_INS_FRONT = 3'd1,
        OP_ROT_LEFT  = 3'd2,
        OP_ROT_RIGHT = 3'd3,
        OP_DUMP      = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    // Action applied to every cell of the chain in the same cycle.
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_INS_BACK,
        ACT_INS_FRONT,
        ACT_ROT_LEFT,
        ACT_ROT_RIGHT
    } act_t;

    typedef struct packed {
        act_t   act;
        count_t count;
    } cell_ctl_t;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    // Sign-extend a 32-bit word, then keep the low VALUE_WIDTH bits.
    function automatic entry_t to_entry(input word_t w);
        entry_t r;
        for (int b = 0; b < VALUE_WIDTH; b++) begin
            if (b < WORD_W) begin
                r[b] = w[b];
            end else begin
                r[b] = w[WORD_W-1];
            end
        end
        return r;
    endfunction

    // Sign-extend an entry from VALUE_WIDTH bits, then keep the low 32 bits.
    function automatic word_t to_word(input entry_t e);
        word_t r;
        for (int b = 0; b < WORD_W; b++) begin
            if (b < VALUE_WIDTH) begin
                r[b] = e[b];
            end else begin
                r[b] = e[VALUE_WIDTH-1];
            end
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/rdq_cell.sv
// One cell of the deque chain: a front-aligned and a back-aligned copy of one slot.
module rdq_cell (
    input  logic                      clk,
    input  rdq_pkg::cell_ctl_t        ctl,
    input  rdq_pkg::entry_t           load_value,
    input  logic [rdq_pkg::IDX_W-1:0] position,
    input  rdq_pkg::entry_t           l_below,
    input  rdq_pkg::entry_t           l_above,
    input  rdq_pkg::entry_t           r_below,
    input  rdq_pkg::entry_t           r_above,
    output rdq_pkg::entry_t           l_entry,
    output rdq_pkg::entry_t           r_entry
);
    import rdq_pkg::*;

    localparam int SUM_W = CNT_W + 1;

    entry_t           l_entry_reg;
    entry_t           l_entry_next;
    entry_t           r_entry_reg;
    entry_t           r_entry_next;
    logic [SUM_W-1:0] pos_w;
    logic [SUM_W-1:0] cnt_w;
    logic [SUM_W-1:0] mirror;
    logic             at_tail;
    logic             at_back;
    logic             at_r_open;
    logic             at_r_front;
    logic             at_first;
    logic             at_last;

    // The front-aligned copy keeps the front in cell 0; the back-aligned copy
    // keeps the back in the last cell. Each cell decides its own move.
    assign pos_w      = SUM_W'(position);
    assign cnt_w      = SUM_W'(ctl.count);
    assign mirror     = pos_w + cnt_w;
    assign at_tail    = (pos_w == cnt_w);
    assign at_back    = ((pos_w + 1'b1) == cnt_w);
    assign at_r_open  = (mirror == SUM_W'(CAPACITY - 1));
    assign at_r_front = (mirror == SUM_W'(CAPACITY));
    assign at_first   = (position == '0);
    assign at_last    = (position == IDX_W'(CAPACITY - 1));

    always_comb
    begin
        l_entry_next = l_entry_reg;
        r_entry_next = r_entry_reg;
        unique case (ctl.act)
            ACT_INS_BACK:
            begin
                l_entry_next = at_tail ? load_value : l_entry_reg;
                r_entry_next = at_last ? load_value : r_above;
            end
            ACT_INS_FRONT:
            begin
                l_entry_next = at_first ? load_value : l_below;
                r_entry_next = at_r_open ? load_value : r_entry_reg;
            end
            ACT_ROT_LEFT:
            begin
                l_entry_next = at_back ? load_value : l_above;
                r_entry_next = at_last ? load_value : r_above;
            end
            ACT_ROT_RIGHT:
            begin
                l_entry_next = at_first ? load_value : l_below;
                r_entry_next = at_r_front ? load_value : r_below;
            end
            default:
            begin
                l_entry_next = l_entry_reg;
                r_entry_next = r_entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        l_entry_reg <= l_entry_next;
        r_entry_reg <= r_entry_next;
    end

    assign l_entry = l_entry_reg;
    assign r_entry = r_entry_reg;

endmodule

>>> hw/rtl/rdq_chain.sv
// Row of deque cells wired as a ring, with the broadcast value for the cycle.
module rdq_chain (
    input  logic               clk,
    input  rdq_pkg::cell_ctl_t ctl,
    input  rdq_pkg::entry_t    ins_value,
    output rdq_pkg::entry_t    front
);
    import rdq_pkg::*;

    entry_t l_q [CAPACITY];
    entry_t r_q [CAPACITY];
    entry_t load_value;

    // Rotations feed the entry leaving one end into the other end.
    always_comb
    begin
        unique case (ctl.act)
            ACT_ROT_LEFT:  load_value = l_q[0];
            ACT_ROT_RIGHT: load_value = r_q[CAPACITY-1];
            default:       load_value = ins_value;
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t l_below;
        entry_t l_above;
        entry_t r_below;
        entry_t r_above;

        if (i == 0)
        begin : g_first
            assign l_below = l_q[CAPACITY-1];
            assign r_below = r_q[CAPACITY-1];
        end
        else
        begin : g_inner_low
            assign l_below = l_q[i-1];
            assign r_below = r_q[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign l_above = l_q[0];
            assign r_above = r_q[0];
        end
        else
        begin : g_inner_high
            assign l_above = l_q[i+1];
            assign r_above = r_q[i+1];
        end

        rdq_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .load_value (load_value),
            .position   (IDX_W'(i)),
            .l_below    (l_below),
            .l_above    (l_above),
            .r_below    (r_below),
            .r_above    (r_above),
            .l_entry    (l_q[i]),
            .r_entry    (r_q[i])
        );
    end

    assign front = l_q[0];

endmodule

>>> hw/rtl/rotating_deque_core.sv
// A single-beat item has its result registered and valid the cycle after its input.
// Insert, rotate and unused opcodes are single-beat items, so with an open output one is taken per cycle.
// A dump of n entries is accepted in the idle state, then sends its n beats from the dump state,
// as the cell chain rotates left once per beat; its first beat passes the dump state and the output register.
// A stalled output holds the next input. Reset clears the state, the entry count and the
// output valid; stored entries are not cleared and are only ever read in occupied slots.
module rotating_deque_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rdq_pkg::OPC_W-1:0]     opcode,
    input  logic signed [rdq_pkg::WORD_W-1:0] value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [rdq_pkg::WORD_W-1:0] entry_value,
    output logic [rdq_pkg::STAT_W-1:0]    status,
    output logic [rdq_pkg::OCC_W-1:0]     occupancy,
    output logic                          last_of_run
);
    import rdq_pkg::*;

    `include "rotating_deque_core_assert.svh"

    state_t    state_reg;
    state_t    state_next;
    count_t    count_reg;
    count_t    count_next;
    count_t    remain_reg;
    count_t    remain_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    word_t     entry_value_reg;
    status_t   status_reg;
    logic [OCC_W-1:0] occupancy_reg;
    logic      last_reg;

    logic      slot_free;
    logic      in_fire;
    logic      full;
    logic      empty;
    op_t       op;
    cell_ctl_t ctl;
    act_t      act;
    entry_t    front;

    logic      emit;
    word_t     emit_value;
    status_t   emit_status;
    logic      emit_last;

    // The output register frees up in the same cycle its beat is taken.
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign in_fire   = in_valid && in_ready;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign op        = op_t'(opcode);

    rdq_chain u_chain (
        .clk       (clk),
        .ctl       (ctl),
        .ins_value (to_entry(value)),
        .front     (front)
    );

    assign ctl.act   = act;
    assign ctl.count = count_reg;

    // Sequencing: single-beat items finish in the idle state. A dump of a
    // non-empty deque walks the chain by rotating left once per beat, so
    // after the last beat the order of the entries is back where it was.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        act         = ACT_NONE;
        emit        = 1'b0;
        emit_value  = '0;
        emit_status = STAT_OK;
        emit_last   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    emit = 1'b1;
                    unique case (op)
                        OP_INS_BACK, OP_INS_FRONT:
                        begin
                            if (full)
                            begin
                                emit_status = STAT_FULL;
                            end
                            else
                            begin
                                act        = (op == OP_INS_BACK) ? ACT_INS_BACK
                                                                 : ACT_INS_FRONT;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_ROT_LEFT, OP_ROT_RIGHT:
                        begin
                            if (empty)
                            begin
                                emit_status = STAT_EMPTY;
                            end
                            else
                            begin
                                act = (op == OP_ROT_LEFT) ? ACT_ROT_LEFT : ACT_ROT_RIGHT;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (empty)
                            begin
                                emit_status = STAT_EMPTY;
                            end
                            else
                            begin
                                // The first dump beat comes from the dump state.
                                emit        = 1'b0;
                                remain_next = count_reg;
                                state_next  = S_DUMP;
                            end
                        end
                        default:
                        begin
                            emit_status = STAT_OK;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (slot_free)
                begin
                    act         = ACT_ROT_LEFT;
                    emit        = 1'b1;
                    emit_value  = to_word(front);
                    emit_last   = (remain_reg == CNT_W'(1));
                    remain_next = remain_reg - 1'b1;
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload; loaded only when a new beat is produced.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            entry_value_reg <= emit_value;
            status_reg      <= emit_status;
            occupancy_reg   <= OCC_W'(count_next);
            last_reg        <= emit_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign entry_value = entry_value_reg;
    assign status      = status_reg;
    assign occupancy   = occupancy_reg;
    assign last_of_run = last_reg;

    // The entry count never goes past the capacity of the chain.
    `RDQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY),
                    "count over capacity")
    // A dump in progress always has beats left to send.
    `RDQ_ASSERT_IMP(a_dump_remain, clk, rst_n, state_reg == S_DUMP, remain_reg != '0,
                    "dump with no beats left")
    // Dumping never changes the number of entries held.
    `RDQ_ASSERT_NEXT(a_dump_count, clk, rst_n, state_reg == S_DUMP, $stable(count_reg),
                     "count moved during dump")
    // An accepted insert into a deque with room grows the count by one.
    `RDQ_ASSERT_NEXT(a_insert_grow, clk, rst_n,
                     in_fire && !full && (op == OP_INS_BACK || op == OP_INS_FRONT),
                     count_reg == $past(count_reg) + 1'b1, "insert did not grow count")

endmodule

>>> dv/rotating_deque_core_tb.sv
// Self-checking testbench for rotating_deque_core: random ops against a shadow deque.
module rotating_deque_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rdq_pkg::*;

    // Opcodes the block does not define. They still answer with one status beat.
    localparam logic [OPC_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OPC_W-1:0] OP_SPARE_HI = 3'd7;

    // Number of random items after the directed opening.
    localparam int RANDOM_ITEMS = 480;
    // Cycles with no beat on either side before the run is declared hung.
    localparam int HANG_LIMIT = 2000;
    // Quiet cycles after the last result beat; every beat is registered once.
    localparam int TAIL_CYCLES = 8;

    // One result beat as it should appear on the output side.
    typedef struct {
        word_t            entry_value;
        status_t          status;
        logic [OCC_W-1:0] occupancy;
        logic             last_of_run;
    } result_beat_t;

    // Shadow copy of the deque plus the queue of result beats still owed by the block.
    // Every accepted input beat is applied here first; each output beat is then
    // compared against the oldest beat owed.
    class deque_mirror;
        entry_t       slots[CAPACITY];
        int unsigned  front;
        int unsigned  count;
        result_beat_t owed[$];
        int           errors;

        function int unsigned held();
            return count;
        endfunction

        function int unsigned waiting();
            return owed.size();
        endfunction

        function void owe(word_t val, status_t st, logic last);
            result_beat_t b;
            b.entry_value = val;
            b.status      = st;
            b.occupancy   = OCC_W'(count);
            b.last_of_run = last;
            owed.push_back(b);
        endfunction

        // Stored width follows VALUE_WIDTH: the 32-bit input is sign-extended and
        // then trimmed, and on the way out the entry is sign-extended back to 32 bits.
        function entry_t narrow(word_t w);
            logic signed [63:0] wide;
            wide = 64'($signed(w));
            return wide[VALUE_WIDTH-1:0];
        endfunction

        function word_t widen(entry_t e);
            logic signed [63:0] wide;
            wide = 64'(e) << (64 - VALUE_WIDTH);
            wide = wide >>> (64 - VALUE_WIDTH);
            return wide[WORD_W-1:0];
        endfunction

        function void apply_op(logic [OPC_W-1:0] op, word_t val);
            entry_t moved;
            case (op)
                OP_INS_BACK, OP_INS_FRONT:
                begin
                    if (count >= CAPACITY) begin
                        // Full: the entry is dropped and nothing moves.
                        owe('0, STAT_FULL, 1'b1);
                    end else begin
                        if (op == OP_INS_BACK) begin
                            slots[(front + count) % CAPACITY] = narrow(val);
                        end else begin
                            front = (front + CAPACITY - 1) % CAPACITY;
                            slots[front] = narrow(val);
                        end
                        count++;
                        owe('0, STAT_OK, 1'b1);
                    end
                end
                OP_ROT_LEFT, OP_ROT_RIGHT:
                begin
                    if (count == 0) begin
                        owe('0, STAT_EMPTY, 1'b1);
                    end else if (op == OP_ROT_LEFT) begin
                        moved = slots[front];
                        slots[(front + count) % CAPACITY] = moved;
                        front = (front + 1) % CAPACITY;
                        owe('0, STAT_OK, 1'b1);
                    end else begin
                        moved = slots[(front + count - 1) % CAPACITY];
                        front = (front + CAPACITY - 1) % CAPACITY;
                        slots[front] = moved;
                        owe('0, STAT_OK, 1'b1);
                    end
                end
                OP_DUMP:
                begin
                    if (count == 0) begin
                        owe('0, STAT_EMPTY, 1'b1);
                    end else begin
                        for (int unsigned i = 0; i < count; i++) begin
                            owe(widen(slots[(front + i) % CAPACITY]), STAT_OK, i + 1 == count);
                        end
                    end
                end
                default:
                begin
                    owe('0, STAT_OK, 1'b1);
                end
            endcase
        endfunction

        function void compare_beat(word_t val, logic [STAT_W-1:0] st,
                                   logic [OCC_W-1:0] occ, logic last);
            result_beat_t b;
            if (owed.size() == 0) begin
                $display("%0t: result beat with nothing owed: entry_value %h status %0d",
                         $time, val, st);
                errors++;
                return;
            end
            b = owed.pop_front();
            if (val !== b.entry_value) begin
                $display("%0t: entry_value expected %h, actual %h", $time, b.entry_value, val);
                errors++;
            end
            if (st !== b.status) begin
                $display("%0t: status expected %0d, actual %0d", $time, b.status, st);
                errors++;
            end
            if (occ !== b.occupancy) begin
                $display("%0t: occupancy expected %0d, actual %0d", $time, b.occupancy, occ);
                errors++;
            end
            if (last !== b.last_of_run) begin
                $display("%0t: last_of_run expected %0d, actual %0d",
                         $time, b.last_of_run, last);
                errors++;
            end
        endfunction

        function void close_out();
            if (owed.size() != 0) begin
                $display("%0t: %0d result beats never arrived", $time, owed.size());
                errors++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [OPC_W-1:0]        opcode = '0;
    logic signed [WORD_W-1:0] value = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [WORD_W-1:0] entry_value;
    logic [STAT_W-1:0]       status;
    logic [OCC_W-1:0]        occupancy;
    logic                    last_of_run;

    deque_mirror mirror = new();

    // Remaining beats in the sender's current burst.
    int burst_left = 0;

    rotating_deque_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .entry_value (entry_value),
        .status      (status),
        .occupancy   (occupancy),
        .last_of_run (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The receiver picks a new behavior each time its tick counter runs out: fully open, mostly open,
    // open on alternate cycles, or mostly stalled. Long dumps therefore see both
    // clean streaming and heavy back-pressure.
    int unsigned sink_mode  = 0;
    int unsigned sink_ticks = 0;
    always @(posedge clk)
    begin
        if (sink_ticks == 0) begin
            sink_mode  <= $urandom_range(0, 3);
            sink_ticks <= 50;
        end else begin
            sink_ticks <= sink_ticks - 1;
        end
        case (sink_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= sink_ticks[0];
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Every output beat is checked at the edge where it is taken.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) begin
            mirror.compare_beat(entry_value, status, occupancy, last_of_run);
        end
    end

    // Hang detection: any beat on either side restarts the count.
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= HANG_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, HANG_LIMIT);
            $display("rotating_deque_core_tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Holds one input beat until it is taken, then records it in the mirror.
    // The valid stays high on return so that the next beat can follow directly.
    task automatic send_beat(input logic [OPC_W-1:0] op, input word_t val);
        in_valid <= 1'b1;
        opcode   <= op;
        value    <= val;
        do @(posedge clk); while (!in_ready);
        mirror.apply_op(op, val);
    endtask

    // Sends one beat inside the burst pattern: at the start of each burst the sender
    // may drop valid for a random gap. A zero gap leaves valid high across bursts.
    task automatic issue(input logic [OPC_W-1:0] op, input word_t val);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 20);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        send_beat(op, val);
    endtask

    // Lowers valid and holds off until every owed result beat has come back.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (mirror.waiting() != 0);
        burst_left = 0;
    endtask

    // Inserts lead while there is room, so the deque fills up to capacity;
    // after that, rotations and full-width dumps take over and inserts hit the
    // full case.
    function automatic logic [OPC_W-1:0] pick_op();
        int unsigned ins_share;
        int unsigned r;
        ins_share = (mirror.held() >= CAPACITY) ? 16 : 40;
        r = $urandom_range(0, 99);
        if (r < ins_share / 2) begin
            return OP_INS_BACK;
        end
        if (r < ins_share) begin
            return OP_INS_FRONT;
        end
        r = $urandom_range(0, 99);
        if (r < 30) begin
            return OP_ROT_LEFT;
        end
        if (r < 60) begin
            return OP_ROT_RIGHT;
        end
        if (r < 90) begin
            return OP_DUMP;
        end
        return OPC_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    endfunction

    function automatic word_t pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty deque: dump, both rotations and the spare opcodes.
        send_beat(OP_DUMP, 32'h1234_5678);
        send_beat(OP_ROT_LEFT, '0);
        send_beat(OP_ROT_RIGHT, '1);
        send_beat(OP_SPARE_LO, '0);
        send_beat(OPC_W'(OP_SPARE_LO + 1), 32'hDEAD_BEEF);
        send_beat(OP_SPARE_HI, '1);

        // Value extremes from both ends, then a dump to read them back in order.
        send_beat(OP_INS_BACK, 32'h8000_0000);
        send_beat(OP_INS_BACK, 32'h7FFF_FFFF);
        send_beat(OP_INS_FRONT, 32'hFFFF_FFFF);
        send_beat(OP_INS_FRONT, 32'h0000_0000);
        send_beat(OP_DUMP, '0);

        // Rotations on a partly filled ring, including a wrap of the front index.
        send_beat(OP_ROT_LEFT, '1);
        send_beat(OP_DUMP, '0);
        send_beat(OP_ROT_RIGHT, '0);
        send_beat(OP_ROT_RIGHT, '0);
        send_beat(OP_DUMP, '1);
        send_beat(OP_SPARE_LO, 32'h0F0F_0F0F);
        send_beat(OP_INS_BACK, 32'h5555_5555);
        send_beat(OP_INS_FRONT, 32'hAAAA_AAAA);
        send_beat(OP_ROT_LEFT, '0);
        send_beat(OP_DUMP, '0);

        // Let the directed part settle completely before the random traffic.
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 39) == 0) begin
                drain();
            end
            issue(pick_op(), pick_value());
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (mirror.waiting() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        mirror.close_out();

        if (mirror.errors == 0) begin
            $display("rotating_deque_core_tb: done, clean");
        end else begin
            $display("rotating_deque_core_tb: done, errors");
        end
        $finish;
    end

endmodule
